// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define PFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define PFQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pfq_pkg.sv =====
package pfq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PRE_W       = 4;
  localparam int CMP_W       = (CNT_W > PRE_W) ? CNT_W : PRE_W;

  localparam int HANDLE_W    = 32;
  localparam int TIME_W      = 32;
  localparam int IVL_W       = 31;
  localparam int FILL_W      = 4;
  localparam int CMD_W       = 2;
  localparam int EV_W        = 3;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 72;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 31;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP = 2'd2;

  localparam logic [EV_W-1:0] EV_ACCEPT   = 3'd0;
  localparam logic [EV_W-1:0] EV_DROP     = 3'd1;
  localparam logic [EV_W-1:0] EV_FRAME    = 3'd2;
  localparam logic [EV_W-1:0] EV_UNDERRUN = 3'd3;
  localparam logic [EV_W-1:0] EV_IDLE     = 3'd4;
  localparam logic [EV_W-1:0] EV_STOP     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFILL  = 4'd1;

  localparam logic [IVL_W-1:0] INTERVAL_RST = 31'd33333;
  localparam logic [PRE_W-1:0] PREFILL_RST  = 4'd3;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } pfq_state_t;

  typedef struct packed {
    logic load;
  } pfq_ctl_t;

endpackage

// ===== rtl/paced_frame_queue.sv =====
// A result is registered and appears on out_* in the cycle after its word is accepted.
// Throughput: one word per cycle; the single output register lets a new word
// in whenever the held result is taken in the same cycle.
// Reset (rst_n low, synchronous): ring empty, time and schedule at zero,
// interval 33333, prefill 3; slot contents are left as they are.
module paced_frame_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pfq_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] frame_handle
  input  logic [pfq_pkg::CMD_W-1:0]         in_tuser,   // [1:0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfq_pkg::OUT_DATA_W-1:0]    out_tdata,  // [31:0] out_handle,
                                                        // [35:32] fill_level,
                                                        // [67:36] gap_ticks
  output logic [pfq_pkg::EV_W-1:0]          out_tuser,  // [2:0] event_res
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pfq_pkg::pfq_ctl_t ctl;
  logic [pfq_pkg::HANDLE_W-1:0] res_handle;
  logic [pfq_pkg::FILL_W-1:0]   res_fill;
  logic [pfq_pkg::TIME_W-1:0]   res_gap;

  assign cfg_ready = 1'b1;
  assign out_tdata = {4'd0, res_gap, res_fill, res_handle};

  pfq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  pfq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_cmd     (in_tuser),
    .in_handle  (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .res_event  (out_tuser),
    .res_handle (res_handle),
    .res_fill   (res_fill),
    .res_gap    (res_gap)
  );

endmodule

// ===== rtl/pfq_ctrl.sv =====
module pfq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output pfq_pkg::pfq_ctl_t ctl
);

  pfq_pkg::pfq_state_t state_r, state_nxt;

  assign in_tready  = (state_r == pfq_pkg::ST_EMPTY) || out_tready;
  assign out_tvalid = (state_r == pfq_pkg::ST_FULL);
  assign ctl.load   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfq_pkg::ST_EMPTY: begin
        if (ctl.load) state_nxt = pfq_pkg::ST_FULL;
      end
      pfq_pkg::ST_FULL: begin
        if (ctl.load) state_nxt = pfq_pkg::ST_FULL;
        else if (out_tready) state_nxt = pfq_pkg::ST_EMPTY;
      end
      default: state_nxt = pfq_pkg::ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pfq_pkg::ST_EMPTY;
    else state_r <= state_nxt;
  end

endmodule

// ===== rtl/pfq_dp.sv =====
module pfq_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pfq_pkg::pfq_ctl_t                ctl,
  input  logic [pfq_pkg::CMD_W-1:0]        in_cmd,
  input  logic [pfq_pkg::HANDLE_W-1:0]     in_handle,
  input  logic                             cfg_we,
  input  logic [pfq_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pfq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic [pfq_pkg::EV_W-1:0]         res_event,
  output logic [pfq_pkg::HANDLE_W-1:0]     res_handle,
  output logic [pfq_pkg::FILL_W-1:0]       res_fill,
  output logic [pfq_pkg::TIME_W-1:0]       res_gap
);

  localparam int PW = pfq_pkg::PTR_W;
  localparam int CW = pfq_pkg::CNT_W;
  localparam int TW = pfq_pkg::TIME_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(pfq_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(pfq_pkg::QUEUE_DEPTH);
  localparam logic [pfq_pkg::CMP_W-1:0] NEED_MAX = pfq_pkg::CMP_W'(pfq_pkg::QUEUE_DEPTH);

  logic [pfq_pkg::HANDLE_W-1:0] slot_r [pfq_pkg::QUEUE_DEPTH];

  logic [pfq_pkg::IVL_W-1:0] interval_r;
  logic [pfq_pkg::PRE_W-1:0] prefill_r;

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic          started_r, started_nxt, has_out_r, has_out_nxt;
  logic [TW-1:0] now_r, now_nxt, due_r, due_nxt, last_r, last_nxt;

  logic [pfq_pkg::EV_W-1:0]     ev_nxt;
  logic [pfq_pkg::HANDLE_W-1:0] oh_nxt;
  logic [TW-1:0]                gap_nxt;
  logic                         slot_we;

  logic [pfq_pkg::CMP_W-1:0] pre_ext, need;
  logic [TW-1:0] now_inc, due_eff, due_diff;
  logic          st_eff;
  logic [pfq_pkg::HANDLE_W-1:0] oldest;
  logic [PW-1:0] wr_inc, rd_inc;

  assign pre_ext = pfq_pkg::CMP_W'(prefill_r);
  always_comb begin
    if (pre_ext == '0) need = pfq_pkg::CMP_W'(1);
    else if (pre_ext > NEED_MAX) need = NEED_MAX;
    else need = pre_ext;
  end

  assign now_inc = now_r + TW'(1);
  assign oldest  = slot_r[rd_ptr_r];
  assign wr_inc  = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
  assign rd_inc  = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);

  // start takes effect on the same tick, so the due test uses the merged values
  assign st_eff   = started_r ||
                    (pfq_pkg::CMP_W'(held_r) >= need);
  assign due_eff  = started_r ? due_r : now_inc;
  assign due_diff = now_inc - due_eff;

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    held_nxt    = held_r;
    started_nxt = started_r;
    has_out_nxt = has_out_r;
    now_nxt     = now_r;
    due_nxt     = due_r;
    last_nxt    = last_r;
    ev_nxt      = pfq_pkg::EV_IDLE;
    oh_nxt      = '0;
    gap_nxt     = '0;
    slot_we     = 1'b0;
    case (in_cmd)
      pfq_pkg::CMD_PUSH: begin
        ev_nxt     = pfq_pkg::EV_ACCEPT;
        slot_we    = 1'b1;
        wr_ptr_nxt = wr_inc;
        if (held_r >= CNT_FULL) begin
          ev_nxt     = pfq_pkg::EV_DROP;
          oh_nxt     = oldest;
          rd_ptr_nxt = rd_inc;
        end else begin
          held_nxt = held_r + CW'(1);
        end
      end
      pfq_pkg::CMD_TICK: begin
        now_nxt     = now_inc;
        started_nxt = st_eff;
        due_nxt     = due_eff;
        if (st_eff && !due_diff[TW-1]) begin
          if (held_r != '0) begin
            ev_nxt      = pfq_pkg::EV_FRAME;
            oh_nxt      = oldest;
            rd_ptr_nxt  = rd_inc;
            held_nxt    = held_r - CW'(1);
            gap_nxt     = has_out_r ? now_inc - last_r : '0;
            due_nxt     = due_eff + TW'(interval_r);
            last_nxt    = now_inc;
            has_out_nxt = 1'b1;
          end else begin
            ev_nxt  = pfq_pkg::EV_UNDERRUN;
            due_nxt = now_inc + TW'(interval_r >> 1);
          end
        end
      end
      pfq_pkg::CMD_STOP: begin
        ev_nxt      = pfq_pkg::EV_STOP;
        wr_ptr_nxt  = '0;
        rd_ptr_nxt  = '0;
        held_nxt    = '0;
        started_nxt = 1'b0;
        has_out_nxt = 1'b0;
        due_nxt     = '0;
        last_nxt    = '0;
      end
      default: ev_nxt = pfq_pkg::EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load && slot_we) slot_r[wr_ptr_r] <= in_handle;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_event  <= ev_nxt;
      res_handle <= oh_nxt;
      res_fill   <= pfq_pkg::FILL_W'(held_nxt);
      res_gap    <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= pfq_pkg::INTERVAL_RST;
      prefill_r  <= pfq_pkg::PREFILL_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        pfq_pkg::CFG_INTERVAL: interval_r <= cfg_wdata;
        pfq_pkg::CFG_PREFILL:  prefill_r  <= cfg_wdata[pfq_pkg::PRE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      held_r    <= '0;
      started_r <= 1'b0;
      has_out_r <= 1'b0;
      now_r     <= '0;
      due_r     <= '0;
      last_r    <= '0;
    end else if (ctl.load) begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      held_r    <= held_nxt;
      started_r <= started_nxt;
      has_out_r <= has_out_nxt;
      now_r     <= now_nxt;
      due_r     <= due_nxt;
      last_r    <= last_nxt;
    end
  end

endmodule

// ===== rtl/pfq_checker.sv =====
`include "assert_macros.svh"

module pfq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pfq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [pfq_pkg::EV_W-1:0]       out_tuser
);

  `PFQ_ASSERT(a_stop_empty, out_tvalid && out_tuser == pfq_pkg::EV_STOP |-> out_tdata[35:32] == 4'd0, "stop result with nonzero fill")
  `PFQ_ASSERT(a_fill_bound, out_tvalid |-> out_tdata[35:32] <= pfq_pkg::QUEUE_DEPTH, "fill above depth")
  `PFQ_ASSERT(a_gap_frame_only, out_tvalid && out_tuser != pfq_pkg::EV_FRAME |-> out_tdata[67:36] == 32'd0, "gap on non-frame result")
  `PFQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `PFQ_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind paced_frame_queue pfq_checker u_pfq_checker (.*);
